### hw/rtl/hbrs_pkg.sv
// ---------------------------------------------------------------------------
// hbrs_pkg: shared types and constants of the histogram engine
// Operation and result codes, register indexes, controller states and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package hbrs_pkg;

   // Field widths of the request, response and register words
   localparam int SAMPLE_BITS    = 32;
   localparam int BIN_FIELD_BITS = 11;
   localparam int SUM_BITS       = 48;
   localparam int STATUS_BITS    = 2;
   localparam int REQ_DATA_BITS  = 56;
   localparam int CSR_INDEX_BITS = 8;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWER = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER = 8'd1;

   // Register reset values
   localparam logic signed [SAMPLE_BITS-1:0] LOWER_RESET = 32'sd0;
   localparam logic signed [SAMPLE_BITS-1:0] UPPER_RESET = 32'sd65536;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] RSTAT_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] RSTAT_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] RSTAT_BINS  = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_FILL  = 2'd1,
      OP_INTEG = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_OFFSET,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_RD,
      ST_WR,
      ST_SUM,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic item_load;
      logic clr_step;
      logic off_calc;
      logic mul;
      logic div_init;
      logic div_step;
      logic fill_rd;
      logic fill_wr;
      logic sum_step;
      logic out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic oor;
      logic div_last;
      logic sum_done;
      logic out_full;
   } dp_stat_type;

endpackage

`default_nettype wire

### hw/rtl/hbrs_ctrl.sv
// ---------------------------------------------------------------------------
// hbrs_ctrl: sequencing controller of the histogram engine
// Walks each command through its datapath steps and hands the result to the
// output register; runs the clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module hbrs_ctrl
   import hbrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire op_type      req_op,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_FILL:  state_in = ST_OFFSET;
                  OP_INTEG: state_in = ST_SUM;
                  OP_NOP:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_DONE;
         end
         ST_OFFSET:   state_in = ST_MUL;
         ST_MUL: begin
            state_in = stat.oor ? ST_DONE : ST_DIV_INIT;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (stat.div_last) state_in = ST_RD;
         end
         ST_RD:       state_in = ST_WR;
         ST_WR:       state_in = ST_DONE;
         ST_SUM: begin
            if (stat.sum_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.out_full) state_in = ST_IDLE;
         end
         default:     state_in = ST_INIT;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT:     cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
         end
         ST_CLEAR:    cmd.clr_step = 1'b1;
         ST_OFFSET:   cmd.off_calc = 1'b1;
         ST_MUL:      cmd.mul      = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_RD:       cmd.fill_rd  = 1'b1;
         ST_WR:       cmd.fill_wr  = 1'b1;
         ST_SUM:      cmd.sum_step = 1'b1;
         ST_DONE:     cmd.out_load = !stat.out_full;
         default:     cmd          = '0;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/hbrs_dp.sv
// ---------------------------------------------------------------------------
// hbrs_dp: datapath of the histogram engine
// Bound registers, bin memory, offset and scale, bit-serial divider, range
// accumulator and the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module hbrs_dp
   import hbrs_pkg::*;
#(
   parameter int NUM_BINS   = 1024,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dp_cmd_type                       cmd,
   output dp_stat_type                           stat,
   input  wire op_type                           req_op,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample,
   input  wire logic        [BIN_FIELD_BITS-1:0] req_first,
   input  wire logic        [BIN_FIELD_BITS-1:0] req_last,
   input  wire logic                             csr_valid,
   input  wire logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic        [SAMPLE_BITS-1:0]    csr_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic             [SUM_BITS-1:0]       rsp_sum,
   output logic             [STATUS_BITS-1:0]    rsp_status
);

   localparam int IDX_W = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
   localparam int DCW   = (IDX_W > 1) ? $clog2(IDX_W) : 1;
   localparam int PW    = SAMPLE_BITS + IDX_W;
   localparam int CW    = (IDX_W + 1 > BIN_FIELD_BITS) ? IDX_W + 1 : BIN_FIELD_BITS;
   localparam logic [IDX_W:0]     NB_SCALE = (IDX_W + 1)'(NUM_BINS);
   localparam logic [CW-1:0]      NB_CW    = CW'(NUM_BINS);
   localparam logic [IDX_W-1:0]   TOP_ADDR = IDX_W'(NUM_BINS - 1);
   localparam logic [DCW-1:0]     DIV_LAST = DCW'(IDX_W - 1);

   // Bound registers
   logic signed [SAMPLE_BITS-1:0] lower_ff, upper_ff;

   // Captured item
   op_type                        op_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic        [CW-1:0]          first_ff, last_ff;

   // Fill path
   logic                    oor_ff, oor_in;
   logic [SAMPLE_BITS-1:0]  off_ff, off_in;
   logic [SAMPLE_BITS-1:0]  span_ff, span_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]        dvd_ff, dvd_in;
   logic [IDX_W-1:0]        quo_ff, quo_in;
   logic [DCW-1:0]          div_cnt_ff, div_cnt_in;
   logic [SAMPLE_BITS:0]    trial;
   logic                    trial_ge;

   // Clear sweep and range sum
   logic [IDX_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [CW-1:0]           k_ff, k_in;
   logic                    sum_vld_ff, sum_vld_in;
   logic [SUM_BITS-1:0]     acc_ff, acc_in;
   logic [SUM_BITS:0]       acc_wide;
   logic                    bad_range;
   logic                    rd_issue;

   // Bin memory
   logic [COUNT_BITS-1:0]   bins_mem [NUM_BINS];
   logic [COUNT_BITS-1:0]   rd_data_ff;
   logic [COUNT_BITS-1:0]   inc_count;
   logic                    mem_rd;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_wr;
   logic [IDX_W-1:0]        wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]     rsp_sum_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   // Write bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_RESET;
         upper_ff <= UPPER_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_LOWER) lower_ff <= csr_data;
         if (csr_index == REG_UPPER) upper_ff <= csr_data;
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff     <= req_op;
         sample_ff <= req_sample;
         first_ff  <= CW'(req_first);
         last_ff   <= CW'(req_last);
      end
   end

   // Offset, span and range check
   always_comb begin
      oor_in  = oor_ff;
      off_in  = off_ff;
      span_in = span_ff;
      if (cmd.item_load) begin
         oor_in = 1'b0;
      end else if (cmd.off_calc) begin
         oor_in  = !((sample_ff >= lower_ff) && (sample_ff < upper_ff));
         off_in  = SAMPLE_BITS'(sample_ff - lower_ff);
         span_in = SAMPLE_BITS'(upper_ff - lower_ff);
      end
   end

   // Scale the offset by the bin count
   assign prod_in = cmd.mul ? PW'(off_ff) * PW'(NB_SCALE) : prod_ff;

   // Restoring divide, one quotient bit per cycle
   assign trial    = {rem_ff, dvd_ff[IDX_W-1]};
   assign trial_ge = trial >= {1'b0, span_ff};

   always_comb begin
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         rem_in     = prod_ff[PW-1:IDX_W];
         dvd_in     = prod_ff[IDX_W-1:0];
         quo_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = trial_ge ? SAMPLE_BITS'(trial - {1'b0, span_ff})
                               : SAMPLE_BITS'(trial);
         dvd_in     = dvd_ff << 1;
         quo_in     = (quo_ff << 1) | IDX_W'(trial_ge);
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      oor_ff     <= oor_in;
      off_ff     <= off_in;
      span_ff    <= span_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   // Clear sweep address, wraps back to zero after the last bin
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) begin
         clr_addr_in = (clr_addr_ff == TOP_ADDR) ? '0 : clr_addr_ff + 1'b1;
      end
   end

   // Range walk: issue one read per cycle, accumulate the read data in the next cycle
   assign bad_range = (first_ff > last_ff) || (last_ff > NB_CW);
   assign rd_issue  = cmd.sum_step && !bad_range && (k_ff < last_ff);
   assign acc_wide  = {1'b0, acc_ff} + (SUM_BITS + 1)'(rd_data_ff);

   always_comb begin
      k_in       = k_ff;
      acc_in     = acc_ff;
      sum_vld_in = rd_issue;
      if (cmd.item_load) begin
         k_in   = CW'(req_first);
         acc_in = '0;
      end else begin
         if (rd_issue) k_in = k_ff + 1'b1;
         if (sum_vld_ff) acc_in = acc_wide[SUM_BITS] ? '1 : acc_wide[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         sum_vld_ff  <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         sum_vld_ff  <= sum_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      acc_ff <= acc_in;
   end

   // Bin memory ports
   assign inc_count = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
   assign mem_rd    = rd_issue || cmd.fill_rd;
   assign rd_addr   = cmd.fill_rd ? quo_ff : k_ff[IDX_W-1:0];
   assign mem_wr    = cmd.clr_step || cmd.fill_wr;
   assign wr_addr   = cmd.clr_step ? clr_addr_ff : quo_ff;
   assign wr_data   = cmd.clr_step ? '0 : inc_count;

   always_ff @(posedge clock) begin
      if (mem_wr) bins_mem[wr_addr] <= wr_data;
      if (mem_rd) rd_data_ff <= bins_mem[rd_addr];
   end

   // Response register
   always_comb begin
      rsp_status_in = RSTAT_OK;
      if ((op_ff == OP_FILL) && oor_ff)     rsp_status_in = RSTAT_RANGE;
      if ((op_ff == OP_INTEG) && bad_range) rsp_status_in = RSTAT_BINS;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sum_ff    <= acc_ff;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Status toward the controller
   assign stat.clr_last = clr_addr_ff == TOP_ADDR;
   assign stat.oor      = oor_ff;
   assign stat.div_last = div_cnt_ff == DIV_LAST;
   assign stat.sum_done = bad_range || (!(k_ff < last_ff) && !sum_vld_ff);
   assign stat.out_full = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

### hw/rtl/histogram_bin_and_range_sum.sv
// ---------------------------------------------------------------------------
// histogram_bin_and_range_sum: fixed-width histogram engine
// Clears, fills and sums a bank of saturating bin counters over a signed
// Q16.16 range set by two bound registers.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake                 contents
//   req_      in         req_tvalid / req_tready   command word
//   rsp_      out        rsp_tvalid / rsp_tready   sum and status word
//   csr_      in         csr_valid / csr_ready     register index and data
//
// After reset a clearing pass over every bin runs before the first word is
// taken; register writes are taken throughout (csr_ready is always high).
// One word at a time: clear sweeps every bin, fill divides the scaled offset
// (one quotient bit per cycle in the divider) and updates one bin, or stops
// early for a sample outside the range, integrate reads stop_bin - start_bin
// bins (one read of the bin memory per cycle), or none for an empty or
// invalid bin range. A finished word waits in the output register, and a
// stalled rsp_tready holds only the hand-over of the next finished word.
// ---------------------------------------------------------------------------
`default_nettype none

module histogram_bin_and_range_sum
   import hbrs_pkg::*;
#(
   parameter int NUM_BINS   = 1024,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req_tdata: sample [31:0], start_bin [42:32], stop_bin [53:43], zero [55:54]
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: cmd [1:0]
   input  wire logic [1:0]                req_tuser,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // rsp_tdata: range_sum [47:0]
   output logic [SUM_BITS-1:0]            rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [STATUS_BITS-1:0]         rsp_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]    csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   op_type      req_op;

   assign req_op    = op_type'(req_tuser);
   assign csr_ready = 1'b1;

   hbrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_op),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hbrs_dp #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_op),
      .req_sample (req_tdata[31:0]),
      .req_first  (req_tdata[42:32]),
      .req_last   (req_tdata[53:43]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_sum    (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

   // Never overwrite a word that still waits on the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("response loaded over a pending word");

   // Counter write follows its read
   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_wr |-> $past(cmd.fill_rd))
      else $error("bin write without preceding read");

   // One word in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   // Exclusive datapath steps
   a_excl_steps: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.item_load, cmd.clr_step, cmd.div_step, cmd.sum_step, cmd.out_load}))
      else $error("overlapping datapath commands");

endmodule

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for histogram_bin_and_range_sum
// Drives command words, bound register writes and response back-pressure,
// tracks the bin counters and bounds in a scoreboard and checks every
// returned sum and status word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   import hbrs_pkg::*;

   localparam int NBINS    = 1024;
   localparam int CNT_BITS = 32;
   localparam logic [63:0] SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;

   // Register indexes the block does not decode
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP   = 8'hFF;

   typedef struct packed {
      logic [SUM_BITS-1:0]    sum;
      logic [STATUS_BITS-1:0] status;
   } answer_type;

   // Bin counters, bounds and the answers still owed by the block
   class hist_tracker;
      logic [CNT_BITS-1:0] counts [NBINS];
      logic signed [SAMPLE_BITS-1:0] lower;
      logic signed [SAMPLE_BITS-1:0] upper;
      answer_type answers_due [$];
      int errors;

      function new();
         foreach (counts[i]) counts[i] = '0;
         lower  = LOWER_RESET;
         upper  = UPPER_RESET;
         errors = 0;
      endfunction

      // Apply a register write; other indexes are ignored
      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [SAMPLE_BITS-1:0] value);
         if (index == REG_LOWER) begin
            lower = value;
         end else if (index == REG_UPPER) begin
            upper = value;
         end
      endfunction

      // Place one sample, saturating the hit counter
      function logic [STATUS_BITS-1:0] bin_sample(logic signed [SAMPLE_BITS-1:0] sample);
         logic signed [63:0] s64;
         logic signed [63:0] lo64;
         logic signed [63:0] hi64;
         logic signed [63:0] span;
         logic [63:0] idx;
         s64  = sample;
         lo64 = lower;
         hi64 = upper;
         span = hi64 - lo64;
         if (span <= 0 || s64 < lo64 || s64 >= hi64) return RSTAT_RANGE;
         idx = ((s64 - lo64) * NBINS) / span;
         if (idx >= NBINS) return RSTAT_RANGE;
         if (counts[int'(idx)] != '1) counts[int'(idx)] = counts[int'(idx)] + 1'b1;
         return RSTAT_OK;
      endfunction

      // Saturating sum over first .. last-1
      function answer_type sum_bins(logic [BIN_FIELD_BITS-1:0] first,
                                    logic [BIN_FIELD_BITS-1:0] last);
         answer_type a;
         logic [63:0] acc;
         int k;
         a = '0;
         if (first > last || last > NBINS) begin
            a.status = RSTAT_BINS;
            return a;
         end
         acc = '0;
         for (k = first; k < last; k++) begin
            acc = acc + counts[k];
            if (acc > SUM_MAX) acc = SUM_MAX;
         end
         a.sum    = acc[SUM_BITS-1:0];
         a.status = RSTAT_OK;
         return a;
      endfunction

      // Note an accepted command word and queue its answer
      function void take_command(op_type op, logic [REQ_DATA_BITS-1:0] data);
         answer_type a;
         a = '0;
         case (op)
            OP_CLEAR: begin
               foreach (counts[i]) counts[i] = '0;
            end
            OP_FILL: begin
               a.status = bin_sample(data[31:0]);
            end
            OP_INTEG: begin
               a = sum_bins(data[42:32], data[53:43]);
            end
            default: begin
            end
         endcase
         answers_due.push_back(a);
      endfunction

      // Compare a returned word with the oldest owed answer
      function void check_answer(logic [SUM_BITS-1:0] sum, logic [STATUS_BITS-1:0] status);
         answer_type want;
         if (answers_due.size() == 0) begin
            $display("%0t: response with none owed, sum %0d status %0d", $time, sum, status);
            errors++;
            return;
         end
         want = answers_due.pop_front();
         if (sum !== want.sum) begin
            $display("%0t: range_sum expected %0d actual %0d", $time, want.sum, sum);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic [1:0]                req_tuser;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [SUM_BITS-1:0]       rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SAMPLE_BITS-1:0]    csr_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   hist_tracker model;

   histogram_bin_and_range_sum #(
      .NUM_BINS   (NBINS),
      .COUNT_BITS (CNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) model.take_command(op_type'(req_tuser), req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) model.check_answer(rsp_tdata, rsp_tuser);
      if (!reset && csr_valid && csr_ready) model.write_reg(csr_index, csr_data);
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Write one register, then drop valid
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [SAMPLE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_bounds(logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi);
      write_csr(REG_LOWER, lo);
      write_csr(REG_UPPER, hi);
   endtask

   // Offer one command word after a random gap; hold until taken
   task automatic send_word(op_type op, logic [SAMPLE_BITS-1:0] sample,
                            logic [BIN_FIELD_BITS-1:0] first,
                            logic [BIN_FIELD_BITS-1:0] last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, last, first, sample};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed answer has come back
   task automatic wait_answers();
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Sample inside the current range, biased toward the low bins and the edges
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic signed [63:0] lo64;
      logic signed [63:0] hi64;
      logic signed [63:0] span;
      logic [63:0] off;
      logic [63:0] r;
      logic [63:0] v;
      int bin;
      lo64 = model.lower;
      hi64 = model.upper;
      span = hi64 - lo64;
      if (span <= 0) return $urandom;
      r = {$urandom, $urandom} % span;
      case ($urandom_range(9))
         0: off = '0;
         1: off = span - 1;
         default: begin
            bin = $urandom_range(1) ? $urandom_range(15) : $urandom_range(NBINS - 1);
            off = (bin * span + r) / NBINS;
         end
      endcase
      v = lo64 + off;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Mostly fills and short integrations, a few clears, idle codes and junk ranges
   task automatic send_random_word();
      int k;
      int len;
      logic [BIN_FIELD_BITS-1:0] f;
      logic [BIN_FIELD_BITS-1:0] l;
      k = $urandom_range(99);
      if (k < 2) begin
         send_word(OP_CLEAR, $urandom, BIN_FIELD_BITS'($urandom), BIN_FIELD_BITS'($urandom));
      end else if (k < 5) begin
         send_word(OP_NOP, $urandom, BIN_FIELD_BITS'($urandom), BIN_FIELD_BITS'($urandom));
      end else if (k < 60) begin
         send_word(OP_FILL, ($urandom_range(99) < 85) ? pick_sample() : $urandom,
                   BIN_FIELD_BITS'($urandom), BIN_FIELD_BITS'($urandom));
      end else begin
         k = $urandom_range(99);
         if (k < 5) begin
            f = '0;
            l = BIN_FIELD_BITS'(NBINS);
         end else if (k < 15) begin
            f = BIN_FIELD_BITS'($urandom);
            l = BIN_FIELD_BITS'($urandom);
         end else begin
            f   = BIN_FIELD_BITS'($urandom_range(1) ? $urandom_range(20)
                                                    : $urandom_range(NBINS));
            len = $urandom_range(16);
            l   = BIN_FIELD_BITS'((f + len > NBINS) ? NBINS : f + len);
         end
         send_word(OP_INTEG, $urandom, f, l);
      end
   endtask

   initial begin
      int p;
      int n;
      logic [SAMPLE_BITS-1:0] a;
      logic [SAMPLE_BITS-1:0] b;
      logic [SAMPLE_BITS-1:0] t;

      model      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_NOP;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset bounds, field extremes, range edges, bad bin ranges
      send_word(OP_NOP, 32'hFFFFFFFF, 11'h7FF, 11'h7FF);
      send_word(OP_INTEG, '0, 11'd0, 11'd1024);
      send_word(OP_FILL, 32'd0, '0, '0);
      send_word(OP_FILL, 32'd65535, '0, '0);
      send_word(OP_FILL, 32'd65536, '0, '0);
      send_word(OP_FILL, 32'hFFFFFFFF, '0, '0);
      send_word(OP_FILL, 32'h7FFFFFFF, '0, '0);
      send_word(OP_FILL, 32'h80000000, '0, '0);
      send_word(OP_FILL, 32'd64, '0, '0);
      send_word(OP_INTEG, '0, 11'd0, 11'd1024);
      send_word(OP_INTEG, '0, 11'd1023, 11'd1024);
      send_word(OP_INTEG, '0, 11'd5, 11'd5);
      send_word(OP_INTEG, '0, 11'd1024, 11'd1024);
      send_word(OP_INTEG, '0, 11'd10, 11'd9);
      send_word(OP_INTEG, '0, 11'd0, 11'd1025);
      send_word(OP_INTEG, '0, 11'h7FF, 11'h7FF);
      send_word(OP_CLEAR, '0, '0, '0);
      send_word(OP_INTEG, '0, 11'd0, 11'd1024);
      wait_answers();

      // Widest range; counters must survive the bound change
      set_bounds(32'h80000000, 32'h7FFFFFFF);
      send_word(OP_FILL, 32'h80000000, '0, '0);
      send_word(OP_FILL, 32'h7FFFFFFE, '0, '0);
      send_word(OP_FILL, 32'h7FFFFFFF, '0, '0);
      wait_answers();
      set_bounds(32'd100, 32'd100);
      send_word(OP_FILL, 32'd100, '0, '0);
      wait_answers();
      set_bounds(32'd200, 32'd100);
      send_word(OP_FILL, 32'd150, '0, '0);
      send_word(OP_INTEG, '0, 11'd0, 11'd1024);
      wait_answers();

      // Writes to undecoded indexes leave the bounds alone
      set_bounds(LOWER_RESET, UPPER_RESET);
      write_csr(REG_SPARE, $urandom);
      write_csr(REG_TOP, 32'hFFFFFFFF);
      send_word(OP_FILL, 32'd64, '0, '0);
      send_word(OP_INTEG, '0, 11'd1, 11'd2);
      wait_answers();

      // Random phases: one bound setting and one idle pattern each
      for (p = 0; p < 8; p++) begin
         a = $urandom;
         b = $urandom;
         case (p)
            0: begin
               a = LOWER_RESET;
               b = UPPER_RESET;
            end
            1, 6: begin
               if ($signed(a) > $signed(b)) begin
                  t = a;
                  a = b;
                  b = t;
               end
            end
            2: begin
               a = $signed(a) >>> 1;
               b = a + $urandom_range(3000, 1);
            end
            3: begin
               a = 32'h80000000;
               b = 32'h7FFFFFFF;
            end
            5: begin
               a = -32'sd5;
               b = -32'sd2;
            end
            7: begin
               a = -32'sd65536;
               b = 32'sd65536;
            end
            default: begin
            end
         endcase
         set_bounds(a, b);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         for (n = 0; n < 72; n++) send_random_word();
         wait_answers();
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end

      repeat (20) @(negedge clock);
      if (model.errors == 0 && model.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #10000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hw/rtl/hbrs_pkg.sv
hw/rtl/hbrs_ctrl.sv
hw/rtl/hbrs_dp.sv
hw/rtl/histogram_bin_and_range_sum.sv
dv/tb.sv
